// File: hw/rtl/sm3_pkg.sv
// ----------------------------------------------------------------------------
// SM3 hash engine package
// Shared word types, SM3 constants and the permutation and expansion functions.
// ----------------------------------------------------------------------------
package sm3_pkg;

  typedef logic [31:0]       word_t;
  typedef logic [7:0][31:0]  vec8_t;

  // Element 0 is word A of the chaining value
  localparam vec8_t SM3_IV = {
    32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
    32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
  };

  localparam word_t TJ_LO     = 32'h79CC4519;
  localparam word_t TJ_HI     = 32'h7A879D8A;
  // Round 16 uses the upper constant rotated by 16
  localparam word_t TJ_HI_R16 = {TJ_HI[15:0], TJ_HI[31:16]};

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] FILL_LEN   = 6'd56;
  localparam logic [5:0] ROUND_SW   = 6'd15;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST  = 3'd7;

  typedef enum logic [1:0] {
    SCHED_HOLD,
    SCHED_BYTE,
    SCHED_WORD
  } sched_op_t;

  typedef struct packed {
    sched_op_t  op;
    logic [7:0] data;
  } sched_ctrl_t;

  function automatic word_t rotl(input word_t x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic word_t perm0(input word_t x);
    return x ^ rotl(x, 9) ^ rotl(x, 17);
  endfunction

  function automatic word_t perm1(input word_t x);
    return x ^ rotl(x, 15) ^ rotl(x, 23);
  endfunction

  // W[j+16] from W[j], W[j+3], W[j+7], W[j+10], W[j+13]
  function automatic word_t expand(input word_t w0, input word_t w3, input word_t w7,
                                   input word_t w10, input word_t w13);
    return perm1(w0 ^ w7 ^ rotl(w13, 15)) ^ rotl(w3, 7) ^ w10;
  endfunction

endpackage

// File: hw/rtl/sm3_if.sv
// ----------------------------------------------------------------------------
// SM3 stream channels
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
interface sm3_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       byte_present;
  logic       message_end;

  modport source (output valid, msg_byte, byte_present, message_end, input ready);
  modport sink   (input valid, msg_byte, byte_present, message_end, output ready);
endinterface

interface sm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: hw/rtl/sm3_sched.sv
// ----------------------------------------------------------------------------
// SM3 block buffer and message schedule
// Gathers bytes into a 512-bit window, then slides it one expanded word per round.
// ----------------------------------------------------------------------------
module sm3_sched (
  input  logic                clk,
  input  sm3_pkg::sched_ctrl_t ctrl,
  output sm3_pkg::word_t      w_j,
  output sm3_pkg::word_t      wp_j
);
  import sm3_pkg::*;

  logic [511:0] win_r;
  word_t        w_new;

  // Word k of the window sits at win_r[511-32k -: 32]
  assign w_j   = win_r[511:480];
  assign wp_j  = win_r[511:480] ^ win_r[383:352];
  assign w_new = expand(win_r[511:480], win_r[415:384], win_r[287:256],
                        win_r[191:160], win_r[95:64]);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      SCHED_BYTE: win_r <= {win_r[503:0], ctrl.data};
      SCHED_WORD: win_r <= {win_r[479:0], w_new};
      default:    win_r <= win_r;
    endcase
  end

endmodule

// File: hw/rtl/sm3_round.sv
// ----------------------------------------------------------------------------
// SM3 compression round
// One round of the compression function, shared by all 64 rounds.
// ----------------------------------------------------------------------------
module sm3_round (
  input  sm3_pkg::vec8_t st,
  input  sm3_pkg::word_t w,
  input  sm3_pkg::word_t wp,
  input  sm3_pkg::word_t tc,
  input  logic           early,
  output sm3_pkg::vec8_t st_nxt
);
  import sm3_pkg::*;

  word_t a12, ss1, ss2, ff, gg, tt1, tt2;

  always_comb begin
    a12 = rotl(st[0], 12);
    ss1 = rotl(a12 + st[4] + tc, 7);
    ss2 = ss1 ^ a12;
    if (early) begin
      ff = st[0] ^ st[1] ^ st[2];
      gg = st[4] ^ st[5] ^ st[6];
    end else begin
      ff = (st[0] & st[1]) | (st[0] & st[2]) | (st[1] & st[2]);
      gg = (st[4] & st[5]) | (~st[4] & st[6]);
    end
    tt1 = ff + st[3] + ss2 + wp;
    tt2 = gg + st[7] + ss1 + w;
    st_nxt[0] = tt1;
    st_nxt[1] = st[0];
    st_nxt[2] = rotl(st[1], 9);
    st_nxt[3] = st[2];
    st_nxt[4] = perm0(tt2);
    st_nxt[5] = st[4];
    st_nxt[6] = rotl(st[5], 19);
    st_nxt[7] = st[6];
  end

endmodule

// File: hw/rtl/sm3_hash_engine.sv
// ----------------------------------------------------------------------------
// SM3 hash engine
// Byte-stream SM3 hasher with an iterative single-round compression core.
// ----------------------------------------------------------------------------
// A message byte is taken while the engine is idle. The byte that completes a
// 64-byte block also starts a compression (64 rounds through the one round
// unit, then the fold into the chaining value), during which no byte is taken.
// A transaction with message_end runs padding through the same byte buffer, one
// byte per cycle except while a filled block is compressed: 0x80, zeros up to
// byte 56 (through a second block when fewer than 9 bytes are free), a
// turnaround state that writes no byte, and 8 length bytes, each padded block
// compressed as it fills. The eight digest words then leave one per cycle while
// out ready is high, and the engine is back at the initial value with cleared counts.
module sm3_hash_engine (
  input  logic           clk,
  input  logic           rst_n,
  sm3_in_if.sink         in_chan,
  sm3_out_if.source      out_chan
);
  import sm3_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_START,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_COMP,
    ST_FOLD,
    ST_OUT
  } state_t;

  state_t       state_r, state_nxt;
  state_t       ret_r, ret_nxt;
  logic [5:0]   round_r, round_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [54:0]  bc_r, bc_nxt;
  logic [63:0]  len_r, len_nxt;
  logic [2:0]   idx_r, idx_nxt;
  word_t        tc_r, tc_nxt;
  vec8_t        wk_r, wk_nxt;
  vec8_t        cv_r, cv_nxt;
  vec8_t        round_out;
  word_t        w_j, wp_j;
  sched_ctrl_t  sched_ctrl;
  logic         start_comp;

  sm3_sched u_sched (
    .clk  (clk),
    .ctrl (sched_ctrl),
    .w_j  (w_j),
    .wp_j (wp_j)
  );

  sm3_round u_round (
    .st     (wk_r),
    .w      (w_j),
    .wp     (wp_j),
    .tc     (tc_r),
    .early  (round_r[5:4] == 2'b00),
    .st_nxt (round_out)
  );

  assign in_chan.ready        = (state_r == ST_IDLE);
  assign out_chan.valid       = (state_r == ST_OUT);
  assign out_chan.digest_word = cv_r[idx_r];
  assign out_chan.word_index  = idx_r;
  assign out_chan.last_word   = (idx_r == WORD_LAST);

  always_comb begin
    state_nxt       = state_r;
    ret_nxt         = ret_r;
    round_nxt       = round_r;
    fill_nxt        = fill_r;
    bc_nxt          = bc_r;
    len_nxt         = len_r;
    idx_nxt         = idx_r;
    tc_nxt          = tc_r;
    wk_nxt          = wk_r;
    cv_nxt          = cv_r;
    sched_ctrl.op   = SCHED_HOLD;
    sched_ctrl.data = '0;
    start_comp      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          if (in_chan.byte_present) begin
            sched_ctrl.op   = SCHED_BYTE;
            sched_ctrl.data = in_chan.msg_byte;
            fill_nxt        = fill_r + 6'd1;
            if (fill_r == FILL_LAST) begin
              bc_nxt     = bc_r + 55'd1;
              start_comp = 1'b1;
              ret_nxt    = in_chan.message_end ? ST_PAD_START : ST_IDLE;
            end else if (in_chan.message_end) begin
              state_nxt = ST_PAD_START;
            end
          end else if (in_chan.message_end) begin
            state_nxt = ST_PAD_START;
          end
        end
      end
      ST_PAD_START: begin
        len_nxt         = {bc_r, fill_r, 3'b000};
        sched_ctrl.op   = SCHED_BYTE;
        sched_ctrl.data = PAD_MARK;
        fill_nxt        = fill_r + 6'd1;
        if (fill_r == FILL_LAST) begin
          start_comp = 1'b1;
          ret_nxt    = ST_PAD_ZERO;
        end else begin
          state_nxt = ST_PAD_ZERO;
        end
      end
      ST_PAD_ZERO: begin
        if (fill_r == FILL_LEN) begin
          state_nxt = ST_PAD_LEN;
        end else begin
          sched_ctrl.op = SCHED_BYTE;
          fill_nxt      = fill_r + 6'd1;
          if (fill_r == FILL_LAST) begin
            start_comp = 1'b1;
            ret_nxt    = ST_PAD_ZERO;
          end
        end
      end
      ST_PAD_LEN: begin
        // Shift out the bit length, most significant byte first
        sched_ctrl.op   = SCHED_BYTE;
        sched_ctrl.data = len_r[63:56];
        len_nxt         = {len_r[55:0], 8'h00};
        fill_nxt        = fill_r + 6'd1;
        if (fill_r == FILL_LAST) begin
          start_comp = 1'b1;
          ret_nxt    = ST_OUT;
        end
      end
      ST_COMP: begin
        sched_ctrl.op = SCHED_WORD;
        wk_nxt        = round_out;
        tc_nxt        = (round_r == ROUND_SW) ? TJ_HI_R16 : {tc_r[30:0], tc_r[31]};
        round_nxt     = round_r + 6'd1;
        if (round_r == ROUND_LAST) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cv_nxt    = cv_r ^ wk_r;
        state_nxt = ret_r;
      end
      ST_OUT: begin
        if (out_chan.ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == WORD_LAST) begin
            cv_nxt    = SM3_IV;
            fill_nxt  = '0;
            bc_nxt    = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Load the working registers from the chaining value and start round 0
    if (start_comp) begin
      state_nxt = ST_COMP;
      round_nxt = '0;
      tc_nxt    = TJ_LO;
      wk_nxt    = cv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      round_r <= '0;
      fill_r  <= '0;
      bc_r    <= '0;
      idx_r   <= '0;
      cv_r    <= SM3_IV;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      round_r <= round_nxt;
      fill_r  <= fill_nxt;
      bc_r    <= bc_nxt;
      idx_r   <= idx_nxt;
      cv_r    <= cv_nxt;
    end
    len_r <= len_nxt;
    tc_r  <= tc_nxt;
    wk_r  <= wk_nxt;
  end

  // The digest leaves only after the final block has been consumed
  a_out_block_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (fill_r == '0))
    else $error("digest presented with bytes still buffered");

  // The last digest word returns the engine to the initial value
  a_restart_iv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && out_chan.last_word) |=>
      (in_chan.ready && (cv_r == SM3_IV) && (bc_r == '0)))
    else $error("engine did not return to the initial value after the digest");

  // A fold follows only the final round of a compression
  a_fold_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FOLD) |-> (($past(state_r) == ST_COMP) && ($past(round_r) == ROUND_LAST)))
    else $error("fold without a complete set of rounds");

endmodule

// File: tb/sm3_digest_checker.sv
// ----------------------------------------------------------------------------
// SM3 digest checker
// Watches the byte and digest channels, keeps its own SM3 model of the
// engine, and compares each digest word with the predicted one.
// ----------------------------------------------------------------------------
module sm3_digest_checker (
  input  logic clk,
  input  logic rst_n,
  sm3_in_if    in_mon,
  sm3_out_if   out_mon,
  output int   fail_count,
  output int   pending
);
  import sm3_pkg::*;

  typedef struct {
    word_t      digest;
    logic [2:0] idx;
    logic       last;
  } digest_beat_t;

  digest_beat_t digest_q[$];

  word_t       hash_state [8];
  logic [7:0]  block_bytes [64];
  logic [5:0]  fill_cnt;
  logic [54:0] block_cnt;

  function automatic word_t rol(input word_t x, input int unsigned n);
    int unsigned k;
    k = n % 32;
    return (k == 0) ? x : ((x << k) | (x >> (32 - k)));
  endfunction

  function automatic word_t mix0(input word_t x);
    return x ^ rol(x, 9) ^ rol(x, 17);
  endfunction

  function automatic word_t mix1(input word_t x);
    return x ^ rol(x, 15) ^ rol(x, 23);
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = SM3_IV[i];
    for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    fill_cnt  = '0;
    block_cnt = '0;
  endfunction

  function automatic void compress_block_bytes();
    word_t w [68];
    word_t a, b, c, d, e, f, g, h;
    word_t ss1, ss2, tt1, tt2, ff, gg, tc;
    for (int j = 0; j < 16; j++)
      w[j] = {block_bytes[4*j], block_bytes[4*j+1], block_bytes[4*j+2], block_bytes[4*j+3]};
    for (int j = 16; j < 68; j++)
      w[j] = mix1(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int j = 0; j < 64; j++) begin
      if (j < 16) begin
        tc = 32'h79CC4519;
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        tc = 32'h7A879D8A;
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      ss1 = rol(rol(a, 12) + e + rol(tc, j), 7);
      ss2 = ss1 ^ rol(a, 12);
      tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + h + ss1 + w[j];
      d = c;
      c = rol(b, 9);
      b = a;
      a = tt1;
      h = g;
      g = rol(f, 19);
      f = e;
      e = mix0(tt2);
    end
    hash_state[0] ^= a; hash_state[1] ^= b; hash_state[2] ^= c; hash_state[3] ^= d;
    hash_state[4] ^= e; hash_state[5] ^= f; hash_state[6] ^= g; hash_state[7] ^= h;
  endfunction

  // Take one byte transaction; on a message end pad, finish and queue the digest
  function automatic void absorb_item(input logic [7:0] b, input logic present,
                                      input logic fin);
    logic [63:0]  bit_len;
    digest_beat_t beat;
    if (present) begin
      block_bytes[fill_cnt] = b;
      fill_cnt = fill_cnt + 6'd1;
      if (fill_cnt == 6'd0) begin
        compress_block_bytes();
        block_cnt = block_cnt + 55'd1;
      end
    end
    if (!fin) return;
    bit_len = {block_cnt, fill_cnt, 3'b000};
    block_bytes[fill_cnt] = 8'h80;
    for (int i = int'(fill_cnt) + 1; i < 64; i++) block_bytes[i] = 8'h00;
    // no room for the length: spill into a second block
    if (fill_cnt > 6'd55) begin
      compress_block_bytes();
      for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) block_bytes[56+i] = bit_len[63-8*i -: 8];
    compress_block_bytes();
    for (int i = 0; i < 8; i++) begin
      beat.digest = hash_state[i];
      beat.idx    = 3'(i);
      beat.last   = (i == 7);
      digest_q.push_back(beat);
    end
    restart_hash();
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    restart_hash();
  end

  always @(posedge clk) begin
    digest_beat_t beat;
    if (!rst_n) begin
      restart_hash();
      digest_q.delete();
    end else begin
      // check the digest side first so a new expectation cannot hide a stray word
      if (out_mon.valid && out_mon.ready) begin
        if (digest_q.size() == 0) begin
          $error("digest_word: expected none, got %h", out_mon.digest_word);
          fail_count++;
        end else begin
          beat = digest_q.pop_front();
          if (out_mon.digest_word !== beat.digest) begin
            $error("digest_word: expected %h, got %h", beat.digest, out_mon.digest_word);
            fail_count++;
          end
          if (out_mon.word_index !== beat.idx) begin
            $error("word_index: expected %0d, got %0d", beat.idx, out_mon.word_index);
            fail_count++;
          end
          if (out_mon.last_word !== beat.last) begin
            $error("last_word: expected %b, got %b", beat.last, out_mon.last_word);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        absorb_item(in_mon.msg_byte, in_mon.byte_present, in_mon.message_end);
    end
    pending = digest_q.size();
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// SM3 hash engine testbench
// Streams directed and random messages into the engine under varying
// back-pressure and lets the digest checker compare every digest word.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned TARGET_ITEMS = 380;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   send_idle;
  int   recv_idle;
  int   items_sent;

  sm3_in_if  in_if ();
  sm3_out_if out_if ();

  sm3_hash_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  sm3_digest_checker digest_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

  // Digest side back-pressure
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Present one transaction and hold it until accepted; called at a falling edge
  task automatic push_item(input logic [7:0] b, input logic present, input logic fin);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.msg_byte     <= b;
    in_if.byte_present <= present;
    in_if.message_end  <= fin;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_message(input int unsigned len, input bit end_on_byte);
    for (int unsigned i = 0; i < len; i++) begin
      // drop in an ignored byte now and then
      if ($urandom_range(9) == 0) push_item(8'($urandom), 1'b0, 1'b0);
      push_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!(end_on_byte && len > 0)) push_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int unsigned len;
    int unsigned pick;
    in_if.valid        = 1'b0;
    in_if.msg_byte     = 8'h00;
    in_if.byte_present = 1'b0;
    in_if.message_end  = 1'b0;
    rst_n      = 1'b0;
    send_idle  = 10;
    recv_idle  = 52;
    items_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty message, end flag only
    push_item(8'hFF, 1'b0, 1'b1);
    // "abc" with the end on the last byte
    push_item(8'h61, 1'b1, 1'b0);
    push_item(8'h62, 1'b1, 1'b0);
    push_item(8'h63, 1'b1, 1'b1);
    // ignored bytes around real ones, end without a byte
    push_item(8'hFF, 1'b0, 1'b0);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hA5, 1'b0, 1'b0);
    push_item(8'hFF, 1'b0, 1'b1);
    // single-byte extremes, then a four-byte pattern ended without a byte
    push_item(8'hFF, 1'b1, 1'b1);
    push_item(8'h00, 1'b1, 1'b1);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hFF, 1'b1, 1'b0);
    push_item(8'h55, 1'b1, 1'b0);
    push_item(8'hAA, 1'b1, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);

    while (items_sent < TARGET_ITEMS) begin
      if (items_sent < TARGET_ITEMS / 3) begin
        send_idle = 10;
        recv_idle = 52;
      end else if (items_sent < 2 * TARGET_ITEMS / 3) begin
        send_idle = 52;
        recv_idle = 10;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      pick = $urandom_range(9);
      // favor lengths near the padding and block boundaries
      if (pick < 4)      len = $urandom_range(12);
      else if (pick < 6) len = $urandom_range(60, 52);
      else if (pick < 8) len = $urandom_range(66, 62);
      else if (pick < 9) len = $urandom_range(130, 118);
      else               len = $urandom_range(200);
      send_message(len, $urandom_range(1));
    end
    in_if.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
